>>> design/dmbm_pkg.sv
// Shared types and constants for the display mode best-match block.
// No dependencies; used by every module of the block.
package dmbm_pkg;

    // Mode table depth; mode_index is sized for it
    localparam int MAX_MODES = 16;

    // Command codes
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_EXACT   = 2'd0;
    localparam logic [1:0] STAT_SUBST   = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;
    localparam logic [1:0] STAT_MISSING = 2'd3;

    // Configuration register indexes
    localparam logic CFG_ROTATIONS   = 1'b0;
    localparam logic CFG_REFLECTIONS = 1'b1;

    localparam int SCORE_W = 27;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [6:0]  depth;
        logic [7:0]  refresh;
    } mode_entry_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [12:0] req_width;
        logic [12:0] req_height;
        logic [6:0]  req_depth;
        logic [7:0]  req_refresh;
        logic [3:0]  rotation_request;
        logic [1:0]  reflection_request;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  mode_index;
        logic [12:0] chosen_width;
        logic [12:0] chosen_height;
        logic [6:0]  chosen_depth;
        logic [7:0]  chosen_refresh;
        logic [3:0]  rotation_granted;
        logic [1:0]  reflection_granted;
    } rsp_t;

    // One registered result of the scan unit
    typedef struct packed {
        mode_entry_t entry;
        logic [25:0] sq_x;
        logic [25:0] sq_y;
        logic [6:0]  abs_d;
        logic [7:0]  abs_r;
        logic        size_hit;
        logic        full_hit;
    } scan_res_t;

endpackage

>>> design/dmbm_mode_ram.sv
// Mode table storage: one write port, one registered read port.
// Depends on dmbm_pkg for the entry type.
module dmbm_mode_ram #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  dmbm_pkg::mode_entry_t wdata,
    input  logic [IDX_W-1:0]     raddr,
    output dmbm_pkg::mode_entry_t rdata
);

    dmbm_pkg::mode_entry_t mem [DEPTH];
    dmbm_pkg::mode_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/dmbm_scan.sv
// Shared scan unit: distances, squares and match flags for one table entry.
// Depends on dmbm_pkg; one registered stage.
module dmbm_scan #(
    parameter int IDX_W = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_vld,
    input  logic [IDX_W-1:0]      in_idx,
    input  dmbm_pkg::mode_entry_t entry,
    input  dmbm_pkg::mode_entry_t target,
    input  dmbm_pkg::mode_entry_t best,
    output logic                  out_vld,
    output logic [IDX_W-1:0]      out_idx,
    output dmbm_pkg::scan_res_t   res
);

    logic [12:0]         dx;
    logic [12:0]         dy;
    dmbm_pkg::scan_res_t res_next;
    dmbm_pkg::scan_res_t res_reg;
    logic                vld_reg;
    logic [IDX_W-1:0]    idx_reg;

    always_comb
    begin
        dx = (target.width > entry.width) ? target.width - entry.width
                                          : entry.width - target.width;
        dy = (target.height > entry.height) ? target.height - entry.height
                                            : entry.height - target.height;
        res_next.entry    = entry;
        res_next.sq_x     = 26'(dx) * 26'(dx);
        res_next.sq_y     = 26'(dy) * 26'(dy);
        res_next.abs_d    = (target.depth > entry.depth) ? target.depth - entry.depth
                                                         : entry.depth - target.depth;
        res_next.abs_r    = (target.refresh > entry.refresh)
                            ? target.refresh - entry.refresh
                            : entry.refresh - target.refresh;
        res_next.size_hit = (entry.width == best.width) && (entry.height == best.height);
        res_next.full_hit = res_next.size_hit && (entry.depth == best.depth)
                            && (entry.refresh == best.refresh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            vld_reg <= in_vld;
            idx_reg <= in_idx;
            res_reg <= res_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_idx = idx_reg;
    assign res     = res_reg;

endmodule

>>> design/display_mode_best_match.sv
// Display mode best-match: table of up to MAX_MODES modes with query search.
// Clear and append complete in the idle state. A query on N entries makes four
// passes (maximum, size, depth/refresh, index) through one scan unit; an empty
// table skips the passes. The result is registered as the block returns to idle,
// where the next command is taken. A finished query holds while a result waits.
// Reset empties the table and clears both masks; table entries undefined until written.
module display_mode_best_match (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  dmbm_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output dmbm_pkg::rsp_t  rsp,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [3:0]      cfg_wdata
);

    localparam int MAX_MODES = dmbm_pkg::MAX_MODES;
    localparam int CNT_W = $clog2(MAX_MODES + 1);
    localparam int IDX_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAX,
        ST_SIZE,
        ST_DR,
        ST_IDX,
        ST_DONE
    } state_t;

    state_t                         state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               iss_reg, iss_next;
    logic                           rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]               rd_idx_reg, rd_idx_next;
    dmbm_pkg::mode_entry_t          req_reg, req_next;
    logic [3:0]                     rot_req_reg, rot_req_next;
    logic [1:0]                     refl_req_reg, refl_req_next;
    dmbm_pkg::mode_entry_t          max_reg, max_next;
    dmbm_pkg::mode_entry_t          best_reg, best_next;
    logic [dmbm_pkg::SCORE_W-1:0]   best_size_reg, best_size_next;
    logic [6:0]                     best_d_reg, best_d_next;
    logic [7:0]                     best_r_reg, best_r_next;
    logic                           size_seen_reg, size_seen_next;
    logic                           d_seen_reg, d_seen_next;
    logic                           r_seen_reg, r_seen_next;
    logic                           found_reg, found_next;
    logic [IDX_W-1:0]               found_idx_reg, found_idx_next;
    logic                           empty_reg, empty_next;
    logic [3:0]                     rot_sup_reg, rot_sup_next;
    logic [1:0]                     refl_sup_reg, refl_sup_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    dmbm_pkg::rsp_t                 rsp_reg, rsp_next;

    logic                           cmd_accept;
    logic                           ram_we;
    dmbm_pkg::mode_entry_t          ram_wdata;
    dmbm_pkg::mode_entry_t          ram_rdata;
    logic                           issue;
    logic                           in_pass;
    logic                           pass_done;
    logic                           scan_vld;
    logic [IDX_W-1:0]               scan_idx;
    dmbm_pkg::scan_res_t            scan_res;
    logic [dmbm_pkg::SCORE_W-1:0]   score;
    logic [3:0]                     rot_hit;

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;

    assign ram_we    = cmd_accept && (cmd.func == dmbm_pkg::FUNC_APPEND)
                       && (count_reg < CNT_W'(MAX_MODES));
    assign ram_wdata = '{width: cmd.req_width, height: cmd.req_height,
                         depth: cmd.req_depth, refresh: cmd.req_refresh};

    assign in_pass   = (state_reg == ST_MAX) || (state_reg == ST_SIZE)
                       || (state_reg == ST_DR) || (state_reg == ST_IDX);
    assign issue     = in_pass && (iss_reg != count_reg);
    assign pass_done = in_pass && (iss_reg == count_reg) && !rd_vld_reg && !scan_vld;

    dmbm_mode_ram #(
        .DEPTH (MAX_MODES),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (iss_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    dmbm_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (rd_vld_reg),
        .in_idx  (rd_idx_reg),
        .entry   (ram_rdata),
        .target  (req_reg),
        .best    (best_reg),
        .out_vld (scan_vld),
        .out_idx (scan_idx),
        .res     (scan_res)
    );

    assign score   = {1'b0, scan_res.sq_x} + {1'b0, scan_res.sq_y};
    // lowest set bit of the granted rotation mask
    assign rot_hit = (rot_req_reg & rot_sup_reg) & (~(rot_req_reg & rot_sup_reg) + 4'd1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        iss_next       = iss_reg;
        rd_vld_next    = issue;
        rd_idx_next    = iss_reg[IDX_W-1:0];
        req_next       = req_reg;
        rot_req_next   = rot_req_reg;
        refl_req_next  = refl_req_reg;
        max_next       = max_reg;
        best_next      = best_reg;
        best_size_next = best_size_reg;
        best_d_next    = best_d_reg;
        best_r_next    = best_r_reg;
        size_seen_next = size_seen_reg;
        d_seen_next    = d_seen_reg;
        r_seen_next    = r_seen_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        empty_next     = empty_reg;
        rot_sup_next   = rot_sup_reg;
        refl_sup_next  = refl_sup_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                dmbm_pkg::CFG_ROTATIONS:   rot_sup_next  = cfg_wdata;
                dmbm_pkg::CFG_REFLECTIONS: refl_sup_next = cfg_wdata[1:0];
                default:                   rot_sup_next  = rot_sup_reg;
            endcase
        end

        if (issue)
        begin
            iss_next = iss_reg + CNT_W'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    unique case (cmd.func)
                        dmbm_pkg::FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        dmbm_pkg::FUNC_APPEND:
                        begin
                            if (ram_we)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        dmbm_pkg::FUNC_QUERY:
                        begin
                            req_next      = ram_wdata;
                            rot_req_next  = cmd.rotation_request;
                            refl_req_next = cmd.reflection_request;
                            max_next      = '0;
                            iss_next      = '0;
                            empty_next    = (count_reg == '0);
                            state_next    = (count_reg == '0) ? ST_DONE : ST_MAX;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end

            ST_MAX:
            begin
                if (scan_vld)
                begin
                    if (scan_res.entry.width > max_reg.width)
                        max_next.width = scan_res.entry.width;
                    if (scan_res.entry.height > max_reg.height)
                        max_next.height = scan_res.entry.height;
                    if (scan_res.entry.depth > max_reg.depth)
                        max_next.depth = scan_res.entry.depth;
                    if (scan_res.entry.refresh > max_reg.refresh)
                        max_next.refresh = scan_res.entry.refresh;
                end
                if (pass_done)
                begin
                    // zero request fields take the table maximum
                    if (req_reg.width == '0)   req_next.width   = max_reg.width;
                    if (req_reg.height == '0)  req_next.height  = max_reg.height;
                    if (req_reg.depth == '0)   req_next.depth   = max_reg.depth;
                    if (req_reg.refresh == '0) req_next.refresh = max_reg.refresh;
                    iss_next       = '0;
                    size_seen_next = 1'b0;
                    state_next     = ST_SIZE;
                end
            end

            ST_SIZE:
            begin
                if (scan_vld && (!size_seen_reg || (score < best_size_reg)))
                begin
                    size_seen_next   = 1'b1;
                    best_size_next   = score;
                    best_next.width  = scan_res.entry.width;
                    best_next.height = scan_res.entry.height;
                end
                if (pass_done)
                begin
                    iss_next    = '0;
                    d_seen_next = 1'b0;
                    r_seen_next = 1'b0;
                    state_next  = ST_DR;
                end
            end

            ST_DR:
            begin
                if (scan_vld && scan_res.size_hit)
                begin
                    if (!d_seen_reg || (scan_res.abs_d < best_d_reg))
                    begin
                        d_seen_next     = 1'b1;
                        best_d_next     = scan_res.abs_d;
                        best_next.depth = scan_res.entry.depth;
                    end
                    if (!r_seen_reg || (scan_res.abs_r < best_r_reg))
                    begin
                        r_seen_next       = 1'b1;
                        best_r_next       = scan_res.abs_r;
                        best_next.refresh = scan_res.entry.refresh;
                    end
                end
                if (pass_done)
                begin
                    iss_next       = '0;
                    found_next     = 1'b0;
                    found_idx_next = '0;
                    state_next     = ST_IDX;
                end
            end

            ST_IDX:
            begin
                if (scan_vld && scan_res.full_hit && !found_reg)
                begin
                    found_next     = 1'b1;
                    found_idx_next = scan_idx;
                end
                if (pass_done)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (empty_reg)
                    begin
                        rsp_next        = '0;
                        rsp_next.status = dmbm_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        rsp_next.chosen_width       = best_reg.width;
                        rsp_next.chosen_height      = best_reg.height;
                        rsp_next.chosen_depth       = best_reg.depth;
                        rsp_next.chosen_refresh     = best_reg.refresh;
                        rsp_next.rotation_granted   = rot_hit;
                        rsp_next.reflection_granted = refl_req_reg & refl_sup_reg;
                        if (!found_reg)
                        begin
                            rsp_next.status     = dmbm_pkg::STAT_MISSING;
                            rsp_next.mode_index = '0;
                        end
                        else
                        begin
                            rsp_next.status     = (req_reg != best_reg) ? dmbm_pkg::STAT_SUBST
                                                                        : dmbm_pkg::STAT_EXACT;
                            rsp_next.mode_index = 4'(found_idx_reg);
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            iss_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            req_reg       <= '0;
            rot_req_reg   <= '0;
            refl_req_reg  <= '0;
            max_reg       <= '0;
            best_reg      <= '0;
            best_size_reg <= '0;
            best_d_reg    <= '0;
            best_r_reg    <= '0;
            size_seen_reg <= 1'b0;
            d_seen_reg    <= 1'b0;
            r_seen_reg    <= 1'b0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            empty_reg     <= 1'b0;
            rot_sup_reg   <= '0;
            refl_sup_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            iss_reg       <= iss_next;
            rd_vld_reg    <= rd_vld_next;
            rd_idx_reg    <= rd_idx_next;
            req_reg       <= req_next;
            rot_req_reg   <= rot_req_next;
            refl_req_reg  <= refl_req_next;
            max_reg       <= max_next;
            best_reg      <= best_next;
            best_size_reg <= best_size_next;
            best_d_reg    <= best_d_next;
            best_r_reg    <= best_r_next;
            size_seen_reg <= size_seen_next;
            d_seen_reg    <= d_seen_next;
            r_seen_reg    <= r_seen_next;
            found_reg     <= found_next;
            found_idx_reg <= found_idx_next;
            empty_reg     <= empty_next;
            rot_sup_reg   <= rot_sup_next;
            refl_sup_reg  <= refl_sup_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for display_mode_best_match: mode table commands in, best-match results out.
// Depends on dmbm_pkg and the display_mode_best_match RTL only.

// Tracks the mode table and the grant masks; predicts every query result.
class mode_match_scoreboard;
    localparam int unsigned TABLE_SLOTS = dmbm_pkg::MAX_MODES;

    dmbm_pkg::mode_entry_t mode_table[TABLE_SLOTS];
    int unsigned           mode_total;
    logic [3:0]            rot_mask;
    logic [1:0]            refl_mask;
    dmbm_pkg::rsp_t        pending_matches[$];
    int unsigned           error_count;
    int unsigned           cmd_count;
    int unsigned           dropped_appends;
    int unsigned           checked_count;
    int unsigned           status_seen[4];

    function new();
        mode_total = 0;
        rot_mask = '0;
        refl_mask = '0;
        error_count = 0;
        cmd_count = 0;
        dropped_appends = 0;
        checked_count = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_reg(logic idx, logic [3:0] data);
        if (idx == dmbm_pkg::CFG_ROTATIONS)
            rot_mask = data;
        else
            refl_mask = data[1:0];
    endfunction

    function longint unsigned abs_diff(int unsigned a, int unsigned b);
        return (a > b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function dmbm_pkg::rsp_t best_match(dmbm_pkg::cmd_t c);
        dmbm_pkg::rsp_t  res;
        int unsigned     mw, mh, md, mr, w, h, d, r, bw, bh, bd, br, idx, i;
        longint unsigned best_size, score, dx, dy, best_d, best_r, s;
        logic [3:0]      rot_hit;
        bit              found;

        res = '0;
        if (mode_total == 0) begin
            res.status = dmbm_pkg::STAT_EMPTY;
            return res;
        end
        mw = 0; mh = 0; md = 0; mr = 0;
        for (i = 0; i < mode_total; i++) begin
            if (mode_table[i].width > mw)   mw = mode_table[i].width;
            if (mode_table[i].height > mh)  mh = mode_table[i].height;
            if (mode_table[i].depth > md)   md = mode_table[i].depth;
            if (mode_table[i].refresh > mr) mr = mode_table[i].refresh;
        end
        w = (c.req_width == 0)   ? mw : c.req_width;
        h = (c.req_height == 0)  ? mh : c.req_height;
        d = (c.req_depth == 0)   ? md : c.req_depth;
        r = (c.req_refresh == 0) ? mr : c.req_refresh;

        // size first: least squared distance, earliest entry keeps a tie
        bw = mode_table[0].width;
        bh = mode_table[0].height;
        best_size = '1;
        for (i = 0; i < mode_total; i++) begin
            dx = abs_diff(w, mode_table[i].width);
            dy = abs_diff(h, mode_table[i].height);
            score = dx * dx + dy * dy;
            if (score < best_size) begin
                best_size = score;
                bw = mode_table[i].width;
                bh = mode_table[i].height;
            end
        end

        // depth and refresh picked independently within the chosen size
        bd = d; br = r;
        best_d = '1; best_r = '1;
        for (i = 0; i < mode_total; i++) begin
            if (mode_table[i].width == bw && mode_table[i].height == bh) begin
                s = abs_diff(d, mode_table[i].depth);
                if (s < best_d) begin
                    best_d = s;
                    bd = mode_table[i].depth;
                end
                s = abs_diff(r, mode_table[i].refresh);
                if (s < best_r) begin
                    best_r = s;
                    br = mode_table[i].refresh;
                end
            end
        end

        found = 1'b0;
        idx = 0;
        for (i = 0; i < mode_total; i++) begin
            if (!found && mode_table[i].width == bw && mode_table[i].height == bh &&
                mode_table[i].depth == bd && mode_table[i].refresh == br) begin
                found = 1'b1;
                idx = i;
            end
        end

        if (!found) begin
            res.status = dmbm_pkg::STAT_MISSING;
            idx = 0;
        end else if (w != bw || h != bh || d != bd || r != br) begin
            res.status = dmbm_pkg::STAT_SUBST;
        end else begin
            res.status = dmbm_pkg::STAT_EXACT;
        end
        res.mode_index     = 4'(idx);
        res.chosen_width   = 13'(bw);
        res.chosen_height  = 13'(bh);
        res.chosen_depth   = 7'(bd);
        res.chosen_refresh = 8'(br);
        // lowest angle wins: scan downward so the last hit is the lowest bit
        rot_hit = c.rotation_request & rot_mask;
        res.rotation_granted = '0;
        for (int b = 3; b >= 0; b--) begin
            if (rot_hit[b]) res.rotation_granted = 4'(1 << b);
        end
        res.reflection_granted = c.reflection_request & refl_mask;
        return res;
    endfunction

    function void note_cmd(dmbm_pkg::cmd_t c);
        dmbm_pkg::rsp_t exp_res;

        cmd_count++;
        case (c.func)
            dmbm_pkg::FUNC_CLEAR: mode_total = 0;
            dmbm_pkg::FUNC_APPEND: begin
                if (mode_total < TABLE_SLOTS) begin
                    mode_table[mode_total].width   = c.req_width;
                    mode_table[mode_total].height  = c.req_height;
                    mode_table[mode_total].depth   = c.req_depth;
                    mode_table[mode_total].refresh = c.req_refresh;
                    mode_total++;
                end else begin
                    dropped_appends++;
                end
            end
            dmbm_pkg::FUNC_QUERY: begin
                exp_res = best_match(c);
                status_seen[exp_res.status]++;
                pending_matches.push_back(exp_res);
            end
            default: ;
        endcase
    endfunction

    function void check_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    function void check_result(dmbm_pkg::rsp_t got);
        dmbm_pkg::rsp_t exp_res;

        if (pending_matches.size() == 0) begin
            $error("result with no query outstanding: status %0d index %0d",
                   got.status, got.mode_index);
            error_count++;
            return;
        end
        exp_res = pending_matches.pop_front();
        checked_count++;
        check_field("status", exp_res.status, got.status);
        check_field("mode_index", exp_res.mode_index, got.mode_index);
        check_field("chosen_width", exp_res.chosen_width, got.chosen_width);
        check_field("chosen_height", exp_res.chosen_height, got.chosen_height);
        check_field("chosen_depth", exp_res.chosen_depth, got.chosen_depth);
        check_field("chosen_refresh", exp_res.chosen_refresh, got.chosen_refresh);
        check_field("rotation_granted", exp_res.rotation_granted, got.rotation_granted);
        check_field("reflection_granted", exp_res.reflection_granted,
                    got.reflection_granted);
    endfunction
endclass

module tb_top;
    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_ITEMS  = 320;
    localparam int unsigned NUM_PHASES   = 5;

    logic           clk;
    logic           rst_n;
    logic           cmd_valid;
    logic           cmd_stall;
    dmbm_pkg::cmd_t cmd;
    logic           rsp_valid;
    logic           rsp_stall;
    dmbm_pkg::rsp_t rsp;
    logic           cfg_we;
    logic           cfg_index;
    logic [3:0]     cfg_wdata;

    mode_match_scoreboard sb;

    bit          idle_on;
    int unsigned hold_trigs;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned cycle_count = 0;
    int unsigned items_sent;
    int unsigned cfg_settings;

    // generator-side copy of the appended modes, used to aim queries
    dmbm_pkg::mode_entry_t recent[$];

    display_mode_best_match u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL display_mode_best_match");
            $finish;
        end
    end

    // transaction monitor
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cmd_valid && !cmd_stall) sb.note_cmd(cmd);
            if (rsp_valid && !rsp_stall) sb.check_result(rsp);
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        rsp_stall = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_trigs != hold_seen) begin
                hold_seen = hold_trigs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_stall <= 1'b1;
            end else begin
                rsp_stall <= idle_on && ($urandom_range(0, 99) < 9);
            end
        end
    end

    function automatic dmbm_pkg::cmd_t make_cmd(logic [1:0] f, int unsigned w,
                                                int unsigned h, int unsigned d,
                                                int unsigned r, int unsigned rot,
                                                int unsigned refl);
        dmbm_pkg::cmd_t c;
        c.func               = f;
        c.req_width          = 13'(w);
        c.req_height         = 13'(h);
        c.req_depth          = 7'(d);
        c.req_refresh        = 8'(r);
        c.rotation_request   = 4'(rot);
        c.reflection_request = 2'(refl);
        return c;
    endfunction

    task automatic send_cmd(dmbm_pkg::cmd_t c);
        if (idle_on && $urandom_range(0, 99) < 9) begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (cmd_stall);
        if (c.func != FUNC_UNUSED) items_sent++;
        if (c.func == dmbm_pkg::FUNC_CLEAR) recent.delete();
        if (c.func == dmbm_pkg::FUNC_APPEND && recent.size() < 16)
            recent.push_back(dmbm_pkg::mode_entry_t'({
                c.req_width, c.req_height, c.req_depth, c.req_refresh}));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (sb.pending_matches.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [3:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_masks(logic [3:0] rot, logic [1:0] refl);
        write_cfg(dmbm_pkg::CFG_ROTATIONS, rot);
        write_cfg(dmbm_pkg::CFG_REFLECTIONS, {2'b00, refl});
        cfg_settings++;
    endtask

    function automatic int unsigned near_val(int unsigned v, int unsigned maxv);
        int t;
        t = int'(v) + int'($urandom_range(0, 8)) - 4;
        if (t < 1) t = 1;
        if (t > int'(maxv)) t = int'(maxv);
        return t;
    endfunction

    function automatic int unsigned aim_field(int unsigned base, int unsigned maxv);
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k < 6)  return base;
        if (k < 11) return near_val(base, maxv);
        if (k < 14) return 0;
        return $urandom_range(0, maxv);
    endfunction

    // few sizes and common depths/rates so entries share sizes and ties show up
    function automatic dmbm_pkg::cmd_t random_append();
        int unsigned size_w[5] = '{640, 800, 1280, 1920, 8191};
        int unsigned size_h[5] = '{480, 600, 720, 1080, 8191};
        int unsigned depths[5] = '{8, 16, 24, 32, 64};
        int unsigned rates[5]  = '{30, 50, 60, 75, 255};
        int unsigned k, w, h, d, r;
        k = $urandom_range(0, 4);
        if ($urandom_range(0, 9) < 7) begin
            w = size_w[k];
            h = size_h[k];
        end else begin
            w = $urandom_range(0, 8191);
            h = $urandom_range(0, 8191);
        end
        d = ($urandom_range(0, 2) != 0) ? depths[$urandom_range(0, 4)] : $urandom_range(0, 64);
        r = ($urandom_range(0, 2) != 0) ? rates[$urandom_range(0, 4)] : $urandom_range(0, 255);
        return make_cmd(dmbm_pkg::FUNC_APPEND, w, h, d, r, $urandom_range(0, 15),
                        $urandom_range(0, 3));
    endfunction

    function automatic dmbm_pkg::cmd_t aimed_query();
        dmbm_pkg::mode_entry_t base;
        if (recent.size() == 0)
            base = dmbm_pkg::mode_entry_t'({13'($urandom_range(0, 8191)),
                                            13'($urandom_range(0, 8191)),
                                            7'($urandom_range(0, 64)),
                                            8'($urandom_range(0, 255))});
        else
            base = recent[$urandom_range(0, recent.size() - 1)];
        return make_cmd(dmbm_pkg::FUNC_QUERY, aim_field(base.width, 8191),
                        aim_field(base.height, 8191), aim_field(base.depth, 64),
                        aim_field(base.refresh, 255),
                        $urandom_range(0, 15), $urandom_range(0, 3));
    endfunction

    function automatic dmbm_pkg::cmd_t noise_cmd();
        case ($urandom_range(0, 4))
            0: return make_cmd(FUNC_UNUSED, $urandom_range(0, 8191), $urandom_range(0, 8191),
                               $urandom_range(0, 64), $urandom_range(0, 255),
                               $urandom_range(0, 15), $urandom_range(0, 3));
            1: return make_cmd(dmbm_pkg::FUNC_QUERY, $urandom_range(0, 8191),
                               $urandom_range(0, 8191),
                               $urandom_range(0, 64), $urandom_range(0, 255),
                               $urandom_range(0, 15), $urandom_range(0, 3));
            2: return make_cmd(dmbm_pkg::FUNC_CLEAR, $urandom_range(0, 8191),
                               $urandom_range(0, 8191),
                               $urandom_range(0, 64), $urandom_range(0, 255),
                               $urandom_range(0, 15), $urandom_range(0, 3));
            3: return make_cmd(dmbm_pkg::FUNC_APPEND, $urandom_range(0, 8191),
                               $urandom_range(0, 8191),
                               $urandom_range(0, 64), $urandom_range(0, 255),
                               $urandom_range(0, 15), $urandom_range(0, 3));
            default: return aimed_query();
        endcase
    endfunction

    // clear (usually), a burst of appends, then queries aimed at the table
    task automatic mode_sequence();
        int unsigned n_app, n_qry;
        if ($urandom_range(0, 9) < 8)
            send_cmd(make_cmd(dmbm_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
        case ($urandom_range(0, 19))
            0:       n_app = 0;
            1, 2, 3: n_app = $urandom_range(12, 20);
            default: n_app = $urandom_range(1, 6);
        endcase
        repeat (n_app) send_cmd(random_append());
        n_qry = $urandom_range(1, 6);
        repeat (n_qry) send_cmd(aimed_query());
    endtask

    initial
    begin
        logic [3:0] rot_set[NUM_PHASES];
        logic [1:0] refl_set[NUM_PHASES];
        int unsigned phase_end;

        clk = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = dmbm_pkg::CFG_ROTATIONS;
        cfg_wdata = '0;
        idle_on = 1'b1;
        hold_trigs = 0;
        items_sent = 0;
        cfg_settings = 0;
        sb = new();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        set_masks(4'b1010, 2'b10);
        send_cmd(make_cmd(dmbm_pkg::FUNC_QUERY, 640, 480, 32, 60, 4'hF, 2'b11)); // empty
        send_cmd(make_cmd(FUNC_UNUSED, 8191, 8191, 64, 255, 4'hF, 2'b11));
        send_cmd(make_cmd(dmbm_pkg::FUNC_APPEND, 8191, 8191, 64, 255, 4'h0, 2'b00));
        send_cmd(make_cmd(dmbm_pkg::FUNC_APPEND, 0, 0, 0, 0, 4'h0, 2'b00));
        send_cmd(make_cmd(dmbm_pkg::FUNC_APPEND, 640, 480, 32, 60, 4'h0, 2'b00));
        send_cmd(make_cmd(dmbm_pkg::FUNC_APPEND, 640, 480, 16, 75, 4'h0, 2'b00));
        // exact, combination missing, substituted, all take maximum, then a near-zero and a partly-zero request
        send_cmd(make_cmd(dmbm_pkg::FUNC_QUERY, 640, 480, 32, 60, 4'b0110, 2'b01));
        send_cmd(make_cmd(dmbm_pkg::FUNC_QUERY, 640, 480, 16, 60, 4'b1000, 2'b10));
        send_cmd(make_cmd(dmbm_pkg::FUNC_QUERY, 650, 470, 30, 59, 4'b1111, 2'b11));
        send_cmd(make_cmd(dmbm_pkg::FUNC_QUERY, 0, 0, 0, 0, 4'b0001, 2'b00));
        send_cmd(make_cmd(dmbm_pkg::FUNC_QUERY, 1, 1, 1, 1, 4'b1010, 2'b11));
        send_cmd(make_cmd(dmbm_pkg::FUNC_QUERY, 0, 480, 64, 0, 4'b0010, 2'b10));
        send_cmd(make_cmd(dmbm_pkg::FUNC_CLEAR, 8191, 8191, 64, 255, 4'hF, 2'b11));
        // empty after clear
        send_cmd(make_cmd(dmbm_pkg::FUNC_QUERY, 0, 0, 0, 0, 4'hF, 2'b11));
        // size tie between two distinct sizes, then depth and refresh ties
        send_cmd(make_cmd(dmbm_pkg::FUNC_APPEND, 110, 100, 10, 30, 4'h0, 2'b00));
        send_cmd(make_cmd(dmbm_pkg::FUNC_APPEND, 100, 110, 24, 50, 4'h0, 2'b00));
        send_cmd(make_cmd(dmbm_pkg::FUNC_APPEND, 110, 100, 20, 40, 4'h0, 2'b00));
        send_cmd(make_cmd(dmbm_pkg::FUNC_QUERY, 105, 105, 15, 35, 4'b1100, 2'b01));
        send_cmd(make_cmd(dmbm_pkg::FUNC_QUERY, 8191, 0, 127, 255, 4'b1000, 2'b10));
        wait_drained();

        // random part, one mask setting per phase, extremes included
        rot_set  = '{4'h0, 4'hF, 4'h1, 4'h8, 4'($urandom_range(0, 15))};
        refl_set = '{2'b00, 2'b11, 2'b01, 2'b10, 2'($urandom_range(0, 3))};
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_masks(rot_set[p], refl_set[p]);
            idle_on = (p != 2);
            if (p == 3) hold_trigs++;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 8)
                    send_cmd(noise_cmd());
                else
                    mode_sequence();
            end
            wait_drained();
        end

        $display("Ran %0d transactions over %0d mask settings; %0d appends hit a full table.",
                 sb.cmd_count, cfg_settings, sb.dropped_appends);
        $display("Checked %0d results: %0d exact, %0d substituted, %0d empty, %0d missing.",
                 sb.checked_count, sb.status_seen[dmbm_pkg::STAT_EXACT],
                 sb.status_seen[dmbm_pkg::STAT_SUBST],
                 sb.status_seen[dmbm_pkg::STAT_EMPTY],
                 sb.status_seen[dmbm_pkg::STAT_MISSING]);
        if (sb.error_count == 0 && sb.pending_matches.size() == 0)
            $display("PASS display_mode_best_match");
        else
            $display("FAIL display_mode_best_match");
        $finish;
    end
endmodule

>>> files.f
design/dmbm_pkg.sv
design/dmbm_mode_ram.sv
design/dmbm_scan.sv
design/display_mode_best_match.sv
sim/tb_top.sv
